// File: design/sbe_pkg.sv
// Shared opcodes, status codes and result type for the stack bytecode execute unit.
package sbe_pkg;

    localparam int DATA_W = 32;

    localparam logic [4:0] OP_ADD    = 5'd1;
    localparam logic [4:0] OP_SUB    = 5'd2;
    localparam logic [4:0] OP_MUL    = 5'd3;
    localparam logic [4:0] OP_LT     = 5'd4;
    localparam logic [4:0] OP_EQ     = 5'd5;
    localparam logic [4:0] OP_JMP    = 5'd6;
    localparam logic [4:0] OP_JT     = 5'd7;
    localparam logic [4:0] OP_JF     = 5'd8;
    localparam logic [4:0] OP_PUSH   = 5'd9;
    localparam logic [4:0] OP_FLOAD  = 5'd10;
    localparam logic [4:0] OP_GLOAD  = 5'd11;
    localparam logic [4:0] OP_FSTORE = 5'd12;
    localparam logic [4:0] OP_GSTORE = 5'd13;
    localparam logic [4:0] OP_PRINT  = 5'd14;
    localparam logic [4:0] OP_POP    = 5'd15;
    localparam logic [4:0] OP_HALT   = 5'd16;
    localparam logic [4:0] OP_CALL   = 5'd17;
    localparam logic [4:0] OP_RET    = 5'd18;
    localparam logic [4:0] OP_PAUSE  = 5'd19;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_PAUSE = 3'd2;
    localparam logic [2:0] ST_STACK = 3'd3;
    localparam logic [2:0] ST_ADDR  = 3'd4;

    typedef struct packed {
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic [2:0]        status;
    } sbe_res_t;

endpackage

// File: design/sbe_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module sbe_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sbe_seq.sv
// Instruction sequencer: decodes one word and walks the stack and global memories.
module sbe_seq #(
    parameter int STACK_DEPTH  = 128,
    parameter int GLOBAL_WORDS = 16,
    parameter int PC_BITS      = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_take,
    input  logic [4:0]         item_op,
    input  logic [31:0]        item_a,
    input  logic [7:0]         item_b,
    input  logic [PC_BITS-1:0] item_npc,
    output logic               res_done,
    input  logic               res_free,
    output logic [PC_BITS-1:0] res_pc,
    output sbe_pkg::sbe_res_t  res
);
    import sbe_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int GAW = (GLOBAL_WORDS > 1) ? $clog2(GLOBAL_WORDS) : 1;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_DEC  = 11'b00000000010,
        S_R1   = 11'b00000000100,
        S_R2   = 11'b00000001000,
        S_R3   = 11'b00000010000,
        S_R4   = 11'b00000100000,
        S_X    = 11'b00001000000,
        S_G    = 11'b00010000000,
        S_C1   = 11'b00100000000,
        S_C2   = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [4:0]         op_reg, op_next;
    logic [31:0]        a_reg, a_next;
    logic [7:0]         b_reg, b_next;
    logic [PC_BITS-1:0] npc_reg, npc_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      fb_reg, fb_next;
    logic               halted_reg, halted_next;
    logic [31:0]        d0_reg, d0_next;
    logic [31:0]        d1_reg, d1_next;
    logic [31:0]        alu_reg, alu_next;
    logic [PC_BITS-1:0] res_pc_reg, res_pc_next;
    sbe_res_t           res_reg, res_next;

    // stack memory port
    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [31:0]   st_wdata, st_rdata;
    // global memory port
    logic           gl_we, gl_re;
    logic [GAW-1:0] gl_waddr, gl_raddr;
    logic [31:0]    gl_wdata, gl_rdata;

    logic [CW-1:0]       n_m1, n_m2, n_p1, n_p2;
    logic [AW-1:0]       fb_m1, fb_m2, nc;
    logic signed [33:0]  idx_s;
    logic                a_tgt_ok, g_ok, fl_bad, fs_bad, n_full, call_full, ret_bad;
    logic                spc_ok, sfp_ok, argc_ok, gad_ok, take;
    logic [31:0]         alu_res;

    assign n_m1  = n_reg - CW'(1);
    assign n_m2  = n_reg - CW'(2);
    assign n_p1  = n_reg + CW'(1);
    assign n_p2  = n_reg + CW'(2);
    assign fb_m1 = fb_reg - AW'(1);
    assign fb_m2 = fb_reg - AW'(2);
    assign nc    = fb_m2 - st_rdata[AW-1:0];

    assign idx_s = $signed({{(34-AW){1'b0}}, fb_reg}) + $signed({{2{a_reg[31]}}, a_reg});
    assign fl_bad = idx_s[33] || (idx_s >= $signed({{(34-CW){1'b0}}, n_reg}));
    assign fs_bad = idx_s[33] || (idx_s >= $signed({{(34-CW){1'b0}}, n_m1}));

    assign a_tgt_ok  = !a_reg[31] && ((a_reg >> PC_BITS) == 32'd0);
    assign spc_ok    = !d0_reg[31] && ((d0_reg >> PC_BITS) == 32'd0);
    assign g_ok      = !a_reg[31] && (a_reg < 32'(GLOBAL_WORDS));
    assign gad_ok    = !st_rdata[31] && (st_rdata < 32'(GLOBAL_WORDS));
    assign n_full    = n_reg >= CW'(STACK_DEPTH);
    assign call_full = ({1'b0, n_reg} + (CW+1)'(3)) > (CW+1)'(STACK_DEPTH);
    assign ret_bad   = (fb_reg < AW'(2))
                    || ({1'b0, n_reg} < ((CW+1)'(fb_reg) + (CW+1)'(2)));
    assign sfp_ok    = d1_reg < 32'(STACK_DEPTH);
    assign argc_ok   = !st_rdata[31] && (st_rdata <= 32'(fb_m2));
    assign take      = (op_reg == OP_JT) ? (st_rdata == 32'd1) : (st_rdata == 32'd0);

    always_comb
    begin
        case (op_reg)
            OP_ADD:  alu_res = d0_reg + st_rdata;
            OP_SUB:  alu_res = d0_reg - st_rdata;
            OP_MUL:  alu_res = d0_reg * st_rdata;
            OP_LT:   alu_res = {31'd0, $signed(d0_reg) < $signed(st_rdata)};
            default: alu_res = {31'd0, d0_reg == st_rdata};
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        npc_next    = npc_reg;
        n_next      = n_reg;
        fb_next     = fb_reg;
        halted_next = halted_reg;
        d0_next     = d0_reg;
        d1_next     = d1_reg;
        alu_next    = alu_reg;
        res_pc_next = res_pc_reg;
        res_next    = res_reg;
        item_take   = 1'b0;
        st_we       = 1'b0;
        st_waddr    = n_reg[AW-1:0];
        st_wdata    = a_reg;
        st_re       = 1'b0;
        st_raddr    = n_m1[AW-1:0];
        gl_we       = 1'b0;
        gl_waddr    = a_reg[GAW-1:0];
        gl_wdata    = st_rdata;
        gl_re       = 1'b0;
        gl_raddr    = st_rdata[GAW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take  = 1'b1;
                    op_next    = item_op;
                    a_next     = item_a;
                    b_next     = item_b;
                    npc_next   = item_npc;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_pc_next = npc_reg;
                res_next    = '{print_valid: 1'b0, print_value: 32'd0, status: ST_OK};
                state_next  = S_FIN;
                if (halted_reg)
                begin
                    res_next.status = ST_HALT;
                end
                else
                begin
                    case (op_reg)
                        OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_EQ:
                        begin
                            if (n_reg < CW'(2))
                            begin
                                res_next.status = ST_STACK;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                st_raddr   = n_m2[AW-1:0];
                                state_next = S_R1;
                            end
                        end
                        OP_JMP:
                        begin
                            if (!a_tgt_ok)
                            begin
                                res_next.status = ST_ADDR;
                            end
                            else
                            begin
                                res_pc_next = a_reg[PC_BITS-1:0];
                            end
                        end
                        OP_JT, OP_JF, OP_GLOAD, OP_PRINT:
                        begin
                            if (n_reg == CW'(0))
                            begin
                                res_next.status = ST_STACK;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                state_next = S_R1;
                            end
                        end
                        OP_PUSH:
                        begin
                            if (n_full)
                            begin
                                res_next.status = ST_STACK;
                            end
                            else
                            begin
                                st_we  = 1'b1;
                                n_next = n_p1;
                            end
                        end
                        OP_FLOAD:
                        begin
                            if (n_full)
                            begin
                                res_next.status = ST_STACK;
                            end
                            else if (fl_bad)
                            begin
                                res_next.status = ST_ADDR;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                st_raddr   = idx_s[AW-1:0];
                                state_next = S_R1;
                            end
                        end
                        OP_FSTORE:
                        begin
                            if (n_reg == CW'(0))
                            begin
                                res_next.status = ST_STACK;
                            end
                            else if (fs_bad)
                            begin
                                res_next.status = ST_ADDR;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                state_next = S_R1;
                            end
                        end
                        OP_GSTORE:
                        begin
                            if (n_reg == CW'(0))
                            begin
                                res_next.status = ST_STACK;
                            end
                            else if (!g_ok)
                            begin
                                res_next.status = ST_ADDR;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                state_next = S_R1;
                            end
                        end
                        OP_POP:
                        begin
                            if (n_reg == CW'(0))
                            begin
                                res_next.status = ST_STACK;
                            end
                            else
                            begin
                                n_next = n_m1;
                            end
                        end
                        OP_HALT:
                        begin
                            halted_next     = 1'b1;
                            res_next.status = ST_HALT;
                        end
                        OP_CALL:
                        begin
                            if (call_full)
                            begin
                                res_next.status = ST_STACK;
                            end
                            else if (!a_tgt_ok)
                            begin
                                res_next.status = ST_ADDR;
                            end
                            else
                            begin
                                st_we      = 1'b1;
                                st_wdata   = {24'd0, b_reg};
                                state_next = S_C1;
                            end
                        end
                        OP_RET:
                        begin
                            if (ret_bad)
                            begin
                                res_next.status = ST_STACK;
                            end
                            else
                            begin
                                st_re      = 1'b1;
                                st_raddr   = fb_reg;
                                state_next = S_R1;
                            end
                        end
                        OP_PAUSE:
                        begin
                            res_next.status = ST_PAUSE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_R1:
            begin
                d0_next    = st_rdata;
                state_next = S_FIN;
                case (op_reg)
                    OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_EQ:
                    begin
                        st_re      = 1'b1;
                        state_next = S_R2;
                    end
                    OP_JT, OP_JF:
                    begin
                        if (take && !a_tgt_ok)
                        begin
                            res_next.status = ST_ADDR;
                        end
                        else
                        begin
                            n_next = n_m1;
                            if (take)
                            begin
                                res_pc_next = a_reg[PC_BITS-1:0];
                            end
                        end
                    end
                    OP_FLOAD:
                    begin
                        st_we    = 1'b1;
                        st_wdata = st_rdata;
                        n_next   = n_p1;
                    end
                    OP_GLOAD:
                    begin
                        if (!gad_ok)
                        begin
                            res_next.status = ST_ADDR;
                        end
                        else
                        begin
                            gl_re      = 1'b1;
                            state_next = S_G;
                        end
                    end
                    OP_FSTORE:
                    begin
                        st_we    = 1'b1;
                        st_waddr = idx_s[AW-1:0];
                        st_wdata = st_rdata;
                        n_next   = n_m1;
                    end
                    OP_GSTORE:
                    begin
                        gl_we  = 1'b1;
                        n_next = n_m1;
                    end
                    OP_PRINT:
                    begin
                        res_next.print_valid = 1'b1;
                        res_next.print_value = st_rdata;
                        n_next               = n_m1;
                    end
                    default:
                    begin
                        // return: saved pc in hand, fetch saved frame base
                        st_re      = 1'b1;
                        st_raddr   = fb_m1;
                        state_next = S_R2;
                    end
                endcase
            end
            S_R2:
            begin
                if (op_reg == OP_RET)
                begin
                    d1_next    = st_rdata;
                    st_re      = 1'b1;
                    st_raddr   = fb_m2;
                    state_next = S_R3;
                end
                else
                begin
                    alu_next   = alu_res;
                    state_next = S_X;
                end
            end
            S_X:
            begin
                st_we      = 1'b1;
                st_waddr   = n_m2[AW-1:0];
                st_wdata   = alu_reg;
                n_next     = n_m1;
                state_next = S_FIN;
            end
            S_R3:
            begin
                if (!sfp_ok || !argc_ok)
                begin
                    res_next.status = ST_STACK;
                    state_next      = S_FIN;
                end
                else if (!spc_ok)
                begin
                    res_next.status = ST_ADDR;
                    state_next      = S_FIN;
                end
                else
                begin
                    d1_next    = {d1_reg[31:AW], nc};
                    alu_next   = d1_reg;
                    st_re      = 1'b1;
                    state_next = S_R4;
                end
            end
            S_R4:
            begin
                // d1 low bits hold the new top index, alu holds the saved frame base
                st_we       = 1'b1;
                st_waddr    = d1_reg[AW-1:0];
                st_wdata    = st_rdata;
                n_next      = CW'(d1_reg[AW-1:0]) + CW'(1);
                fb_next     = alu_reg[AW-1:0];
                res_pc_next = d0_reg[PC_BITS-1:0];
                state_next  = S_FIN;
            end
            S_G:
            begin
                st_we      = 1'b1;
                st_wdata   = gl_rdata;
                st_waddr   = n_m1[AW-1:0];
                state_next = S_FIN;
            end
            S_C1:
            begin
                st_we      = 1'b1;
                st_waddr   = n_p1[AW-1:0];
                st_wdata   = 32'(fb_reg);
                state_next = S_C2;
            end
            S_C2:
            begin
                st_we       = 1'b1;
                st_waddr    = n_p2[AW-1:0];
                st_wdata    = 32'(npc_reg);
                fb_next     = n_p2[AW-1:0];
                n_next      = n_reg + CW'(3);
                res_pc_next = a_reg[PC_BITS-1:0];
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            n_reg      <= '0;
            fb_reg     <= '0;
            halted_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            fb_reg     <= fb_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        npc_reg    <= npc_next;
        d0_reg     <= d0_next;
        d1_reg     <= d1_next;
        alu_reg    <= alu_next;
        res_pc_reg <= res_pc_next;
        res_reg    <= res_next;
    end

    sbe_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .DW    (32)
    ) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    sbe_ram #(
        .DEPTH (GLOBAL_WORDS),
        .AW    (GAW),
        .DW    (32)
    ) u_glob_ram (
        .clk   (clk),
        .we    (gl_we),
        .waddr (gl_waddr),
        .wdata (gl_wdata),
        .re    (gl_re),
        .raddr (gl_raddr),
        .rdata (gl_rdata)
    );

    assign res_done = (state_reg == S_FIN);
    assign res_pc   = res_pc_reg;
    assign res      = res_reg;

endmodule

// File: design/stack_bytecode_execute_unit_core.sv
// Top level of the stack bytecode execute unit: input buffer, sequencer and output register.
//
// One input word is one fetched instruction (opcode, immediates, fall-through pc);
// one output word gives the next fetch pc, an optional printed value and a status.
// Operand stack and global store live in synchronous RAMs with one read port each;
// every stack access of an instruction is a separate RAM cycle. Push, pop, jump,
// halt, pause, unknown opcodes and faults caught at decode are settled at decode;
// return makes four stack reads in a row and call three stack writes. Arithmetic,
// global load, print, conditional jumps, frame load, frame store and global store
// go on to further stack or global accesses. A global load or taken jump with a bad
// address, or a return with a bad saved frame, ends as soon as the fault is seen.
// A one-word input buffer takes the next instruction while the
// current one executes, and the output register holds a finished word while the
// sequencer moves on. After halt every word returns status halted.
// Stack and global entries must be written before they are read; there is no
// clearing pass after reset.
module stack_bytecode_execute_unit_core #(
    parameter int STACK_DEPTH  = 128,
    parameter int GLOBAL_WORDS = 16,
    parameter int PC_BITS      = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [4:0]          opcode,
    input  logic signed [31:0]  operand_a,
    input  logic [7:0]          operand_b,
    input  logic [PC_BITS-1:0]  next_pc,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PC_BITS-1:0]  new_pc,
    output logic                print_valid,
    output logic signed [31:0]  print_value,
    output logic [2:0]          status
);
    import sbe_pkg::*;

    // input buffer
    logic               buf_valid_reg, buf_valid_next;
    logic [4:0]         buf_op_reg;
    logic [31:0]        buf_a_reg;
    logic [7:0]         buf_b_reg;
    logic [PC_BITS-1:0] buf_npc_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [PC_BITS-1:0] out_pc_reg;
    sbe_res_t           out_res_reg;

    logic               seq_take, seq_done, out_free, in_fire;
    logic [PC_BITS-1:0] seq_pc;
    sbe_res_t           seq_res;

    assign in_stall = buf_valid_reg;
    assign in_fire  = in_valid && !buf_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (seq_take)
        begin
            buf_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            buf_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (seq_done && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_op_reg  <= opcode;
            buf_a_reg   <= operand_a;
            buf_b_reg   <= operand_b;
            buf_npc_reg <= next_pc;
        end
        if (seq_done && out_free)
        begin
            out_pc_reg  <= seq_pc;
            out_res_reg <= seq_res;
        end
    end

    sbe_seq #(
        .STACK_DEPTH  (STACK_DEPTH),
        .GLOBAL_WORDS (GLOBAL_WORDS),
        .PC_BITS      (PC_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (buf_valid_reg),
        .item_take  (seq_take),
        .item_op    (buf_op_reg),
        .item_a     (buf_a_reg),
        .item_b     (buf_b_reg),
        .item_npc   (buf_npc_reg),
        .res_done   (seq_done),
        .res_free   (out_free),
        .res_pc     (seq_pc),
        .res        (seq_res)
    );

    assign out_valid   = out_valid_reg;
    assign new_pc      = out_pc_reg;
    assign print_valid = out_res_reg.print_valid;
    assign print_value = out_res_reg.print_value;
    assign status      = out_res_reg.status;

    // sequencer only pulls a word that is sitting in the buffer
    a_take_needs_buf: assert property (@(posedge clk) disable iff (!rst_n)
        seq_take |-> buf_valid_reg)
        else $error("sequencer took a word from an empty buffer");

    // a finished word and a new pull never happen in the same cycle
    a_done_not_take: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> !seq_take)
        else $error("sequencer finished and pulled in the same cycle");

    // printed values only come with an ok status
    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.print_valid) |-> (out_res_reg.status == ST_OK))
        else $error("print word carries a non-ok status");

endmodule
